// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: screen geometry,
// request and command codes, and the request, response and queue beats.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;

  localparam int ADDR_W  = $clog2(CELL_COUNT);
  localparam int ROW_CW  = $clog2(SCREEN_HEIGHT);
  localparam int COL_CW  = $clog2(SCREEN_WIDTH);

  localparam int TYPE_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int ENTRY_W = 16;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int COLOR_W = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd7;
  localparam logic [ENTRY_W-1:0] INIT_CELL    = {RESET_COLOR, SPACE_CODE};

  localparam logic [TYPE_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_READ  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;

  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_NOP     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CHAR    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_NEWLINE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  typedef struct packed {
    logic [TYPE_W-1:0]  req_type;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
  } tcw_req_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] cell_entry;
    logic [ROW_W-1:0]   cursor_row;
    logic [COL_W-1:0]   cursor_col;
    logic               did_scroll;
  } tcw_rsp_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] index;
  } tcw_cmd_t;

endpackage

// ===== rtl/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front
// Request intake: decodes each request beat into a command and holds it in
// a short queue for the execution side.
// ----------------------------------------------------------------------------
module tcw_front
  import tcw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  tcw_req_t req,
  input  logic     init_busy,
  output logic     q_valid,
  output tcw_cmd_t q_head,
  input  logic     q_pop
);

  tcw_cmd_t            q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                push;
  tcw_cmd_t            cmd_in;

  always_comb begin
    cmd_in.char_code = req.char_code;
    cmd_in.index     = ADDR_W'(req.cell_index);
    unique case (req.req_type)
      REQ_PUT:   cmd_in.cmd = (req.char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_CHAR;
      REQ_READ:  cmd_in.cmd = (32'(req.cell_index) < 32'(CELL_COUNT)) ? CMD_READ : CMD_NOP;
      REQ_CLEAR: cmd_in.cmd = CMD_CLEAR;
      default:   cmd_in.cmd = CMD_NOP;
    endcase
  end

  assign req_stall = init_busy || (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign push      = req_valid && !req_stall;
  assign q_valid   = (count != '0);
  assign q_head    = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back
// Command execution: owns the screen store and cursor, runs puts, reads,
// scroll copies and fill sweeps, and holds the response register.
// ----------------------------------------------------------------------------
module tcw_back
  import tcw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [COLOR_W-1:0] text_color,
  input  logic               q_valid,
  input  tcw_cmd_t           q_head,
  output logic               q_pop,
  output logic               init_busy,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output tcw_rsp_t           rsp
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_COPY  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FILL  = 3'd4;

  localparam logic [ROW_CW-1:0] ROW_LAST  = ROW_CW'(SCREEN_HEIGHT - 1);
  localparam logic [COL_CW-1:0] COL_LAST  = COL_CW'(SCREEN_WIDTH - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELL_COUNT - SCREEN_WIDTH - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELL_COUNT - 1);

  logic [2:0]          state, state_next;
  logic [ADDR_W-1:0]   cnt, cnt_next;
  logic [ROW_CW-1:0]   row, row_next;
  logic [COL_CW-1:0]   col, col_next;
  logic [ADDR_W-1:0]   cur_addr, addr_next;
  logic [ENTRY_W-1:0]  fill_value, fill_value_next;
  tcw_rsp_t            pend_rsp, pend_rsp_next;
  logic                init_busy_next;

  logic                slot_free;
  logic                scroll;
  logic                emit;
  tcw_rsp_t            emit_rsp;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  function automatic tcw_rsp_t make_rsp(input logic [ENTRY_W-1:0] entry,
                                        input logic [ROW_CW-1:0] r,
                                        input logic [COL_CW-1:0] c,
                                        input logic s);
    tcw_rsp_t v;
    v.cell_entry = entry;
    v.cursor_row = ROW_W'(r);
    v.cursor_col = COL_W'(c);
    v.did_scroll = s;
    return v;
  endfunction

  tcw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign slot_free = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    row_next        = row;
    col_next        = col;
    addr_next       = cur_addr;
    fill_value_next = fill_value;
    pend_rsp_next   = pend_rsp;
    init_busy_next  = init_busy;
    scroll          = 1'b0;
    emit            = 1'b0;
    emit_rsp        = '0;
    q_pop           = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = cnt;
    ram_wdata       = fill_value;
    ram_raddr       = ADDR_W'(cnt + ROW_STEP);

    unique case (state)
      ST_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          unique case (q_head.cmd)
            CMD_CHAR: begin
              ram_we    = 1'b1;
              ram_waddr = cur_addr;
              ram_wdata = {text_color, q_head.char_code};
              addr_next = cur_addr + 1'b1;
              if (col == COL_LAST) begin
                col_next = '0;
                if (row == ROW_LAST) begin
                  scroll = 1'b1;
                end else begin
                  row_next = row + 1'b1;
                end
              end else begin
                col_next = col + 1'b1;
              end
            end
            CMD_NEWLINE: begin
              col_next = '0;
              if (row == ROW_LAST) begin
                scroll = 1'b1;
              end else begin
                row_next  = row + 1'b1;
                addr_next = cur_addr + ROW_STEP - ADDR_W'(col);
              end
            end
            CMD_READ: begin
              ram_raddr     = q_head.index;
              pend_rsp_next = make_rsp('0, row, col, 1'b0);
              state_next    = ST_READ;
            end
            CMD_CLEAR: begin
              row_next        = '0;
              col_next        = '0;
              addr_next       = '0;
              cnt_next        = '0;
              fill_value_next = {text_color, SPACE_CODE};
              pend_rsp_next   = make_rsp('0, '0, '0, 1'b0);
              state_next      = ST_FILL;
            end
            default: begin
              emit     = 1'b1;
              emit_rsp = make_rsp('0, row, col, 1'b0);
            end
          endcase
          if (q_head.cmd == CMD_CHAR || q_head.cmd == CMD_NEWLINE) begin
            if (scroll) begin
              row_next      = ROW_LAST;
              col_next      = '0;
              addr_next     = LAST_BASE;
              cnt_next      = '0;
              pend_rsp_next = make_rsp('0, ROW_LAST, '0, 1'b1);
              state_next    = ST_COPY;
            end else begin
              emit     = 1'b1;
              emit_rsp = make_rsp('0, row_next, col_next, 1'b0);
            end
          end
        end
      end
      ST_READ: begin
        emit                = 1'b1;
        emit_rsp            = pend_rsp;
        emit_rsp.cell_entry = ram_rdata;
        state_next          = ST_IDLE;
      end
      ST_COPY: begin
        ram_we    = (cnt != '0);
        ram_waddr = cnt - 1'b1;
        ram_wdata = ram_rdata;
        cnt_next  = cnt + 1'b1;
        if (cnt == COPY_LAST) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        ram_we          = 1'b1;
        ram_waddr       = cnt - 1'b1;
        ram_wdata       = ram_rdata;
        fill_value_next = {text_color, SPACE_CODE};
        state_next      = ST_FILL;
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if (cnt == CELL_LAST) begin
          state_next     = ST_IDLE;
          init_busy_next = 1'b0;
          if (!init_busy) begin
            emit     = 1'b1;
            emit_rsp = pend_rsp;
          end
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL;
      cnt        <= '0;
      row        <= '0;
      col        <= '0;
      cur_addr   <= '0;
      fill_value <= INIT_CELL;
      init_busy  <= 1'b1;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      row        <= row_next;
      col        <= col_next;
      cur_addr   <= addr_next;
      fill_value <= fill_value_next;
      init_busy  <= init_busy_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_rsp <= pend_rsp_next;
    if (emit) begin
      rsp <= emit_rsp;
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!rsp_valid || !rsp_stall))
    else $error("response produced while response register is held");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == ST_IDLE && !init_busy))
    else $error("queue popped outside idle");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (row <= ROW_LAST) && (col <= COL_LAST))
    else $error("cursor out of screen");

  a_addr_track: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |->
      (32'(cur_addr) == 32'(row) * SCREEN_WIDTH + 32'(col)))
    else $error("cursor address out of step with row and column");
`endif

endmodule

// ===== rtl/text_console_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text-mode console engine with scroll: screen store, cursor and text color.
// ----------------------------------------------------------------------------
// One response beat per request beat, in order. Puts that do not scroll,
// unknown requests and out-of-range reads finish in the idle state of the
// execution unit and sustain one request per cycle while rsp_stall is low;
// an in-range read also passes through a read state (registered store read).
// A put that scrolls holds the execution unit while one store port copies a
// cell per cycle, then the bottom row is blanked. A clear sweeps the store
// one cell per cycle. After reset a clearing pass fills the store while
// req_stall stays high; color writes are taken at any time.
module text_console_writer_top
  import tcw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  tcw_req_t           req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output tcw_rsp_t           rsp,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COLOR_W-1:0] cfg_data
);

  logic [COLOR_W-1:0] text_color;
  logic               init_busy;
  logic               q_valid;
  tcw_cmd_t           q_head;
  logic               q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (cfg_valid && cfg_ready) begin
      text_color <= cfg_data;
    end
  end

  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .init_busy (init_busy),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  tcw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .text_color (text_color),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .init_busy  (init_busy),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text console writer. A short opening table
// drives reads at the store edges, out-of-range and unknown requests, odd
// character codes, a row wrap, scrolls and a clear. Random phases follow,
// built from text runs, newline runs, reads, clears and unknown requests,
// each opened by a text color write. A screen mirror in the bench predicts
// every response beat that the opening table does not give itself, and
// random idling on both channels exercises the handshakes.
// ----------------------------------------------------------------------------
module tb;
  import tcw_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int INDEX_MAX   = (1 << INDEX_W) - 1;
  localparam int PHASE_ITEMS = 30;
  localparam int PHASES      = 5;

  typedef struct {
    tcw_req_t beat;
    int       reps;
    bit       typed;
    tcw_rsp_t want;
  } plan_step_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  tcw_req_t           req       = '0;
  logic               rsp_stall = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [COLOR_W-1:0] cfg_data  = '0;
  logic               req_stall;
  logic               rsp_valid;
  logic               cfg_ready;
  tcw_rsp_t           rsp;

  logic [ENTRY_W-1:0] screen_mirror [CELL_COUNT];
  int unsigned        mirror_row;
  int unsigned        mirror_col;
  logic [COLOR_W-1:0] mirror_color;

  tcw_rsp_t   replies_due [$];
  plan_step_t opening_plan [$];
  tcw_rsp_t   oldest_reply;

  int fails        = 0;
  int beats_sent   = 0;
  int puts_sent    = 0;
  int reads_sent   = 0;
  int clears_sent  = 0;
  int scrolls_seen = 0;
  int color_writes = 0;
  int stall_left   = 0;
  bit calm         = 1'b0;

  text_console_writer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void mirror_fill(logic [COLOR_W-1:0] color);
    for (int k = 0; k < CELL_COUNT; k++) screen_mirror[k] = {color, SPACE_CODE};
    mirror_row = 0;
    mirror_col = 0;
  endfunction

  function automatic tcw_rsp_t console_apply(tcw_req_t r);
    tcw_rsp_t o;
    bit rolled;
    o = '0;
    rolled = 1'b0;
    case (r.req_type)
      REQ_PUT: begin
        if (r.char_code == NEWLINE_CODE) begin
          mirror_row++;
          mirror_col = 0;
        end else begin
          screen_mirror[mirror_row * SCREEN_WIDTH + mirror_col] = {mirror_color, r.char_code};
          mirror_col++;
        end
        if (mirror_col >= SCREEN_WIDTH) begin
          mirror_col = 0;
          mirror_row++;
        end
        if (mirror_row >= SCREEN_HEIGHT) begin
          mirror_row = SCREEN_HEIGHT - 1;
          for (int k = 0; k < CELL_COUNT; k++) begin
            if (k < CELL_COUNT - SCREEN_WIDTH) screen_mirror[k] = screen_mirror[k + SCREEN_WIDTH];
            else screen_mirror[k] = {mirror_color, SPACE_CODE};
          end
          rolled = 1'b1;
          scrolls_seen++;
        end
      end
      REQ_READ: begin
        if (r.cell_index < CELL_COUNT) o.cell_entry = screen_mirror[r.cell_index];
      end
      REQ_CLEAR: begin
        mirror_fill(mirror_color);
      end
      default: ;
    endcase
    o.cursor_row = mirror_row[ROW_W-1:0];
    o.cursor_col = mirror_col[COL_W-1:0];
    o.did_scroll = rolled;
    return o;
  endfunction

  function automatic tcw_rsp_t status(logic [ENTRY_W-1:0] entry, int row, int col, bit scr);
    tcw_rsp_t o;
    o.cell_entry = entry;
    o.cursor_row = row[ROW_W-1:0];
    o.cursor_col = col[COL_W-1:0];
    o.did_scroll = scr;
    return o;
  endfunction

  function automatic logic [CHAR_W-1:0] text_byte();
    logic [CHAR_W-1:0] ch;
    ch = CHAR_W'($urandom_range(0, 255));
    if (ch == NEWLINE_CODE) ch = SPACE_CODE;
    return ch;
  endfunction

  task automatic add_step(logic [TYPE_W-1:0] kind, logic [CHAR_W-1:0] ch,
                          logic [INDEX_W-1:0] idx, int reps, bit typed = 1'b0,
                          tcw_rsp_t want = '0);
    plan_step_t s;
    s.beat.req_type   = kind;
    s.beat.char_code  = ch;
    s.beat.cell_index = idx;
    s.reps            = reps;
    s.typed           = typed;
    s.want            = want;
    opening_plan.push_back(s);
  endtask

  task automatic send_beat(tcw_req_t r, bit typed, tcw_rsp_t want);
    tcw_rsp_t guess;
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    guess = console_apply(r);
    replies_due.push_back(typed ? want : guess);
    beats_sent++;
    case (r.req_type)
      REQ_PUT:   puts_sent++;
      REQ_READ:  reads_sent++;
      REQ_CLEAR: clears_sent++;
      default: ;
    endcase
  endtask

  task automatic issue(tcw_req_t r, bit typed = 1'b0, tcw_rsp_t want = '0);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    send_beat(r, typed, want);
  endtask

  task automatic set_color(logic [COLOR_W-1:0] color);
    req_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    cfg_data  <= color;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mirror_color = color;
    color_writes++;
  endtask

  task automatic run_phase(int n);
    int made;
    int len;
    int unsigned pick;
    int unsigned sel;
    tcw_req_t r;
    made = 0;
    while (made < n) begin
      pick         = $urandom_range(0, 99);
      r.char_code  = CHAR_W'($urandom_range(0, 255));
      r.cell_index = INDEX_W'($urandom_range(0, INDEX_MAX));
      if (pick < 50) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(70, 100) : $urandom_range(1, 12);
        r.req_type = REQ_PUT;
        repeat (len) begin
          r.char_code  = text_byte();
          r.cell_index = INDEX_W'($urandom_range(0, INDEX_MAX));
          issue(r);
        end
        made += len;
        if ($urandom_range(0, 1) == 1) begin
          r.char_code = NEWLINE_CODE;
          issue(r);
          made++;
        end
      end else if (pick < 65) begin
        len = $urandom_range(1, 4);
        r.req_type  = REQ_PUT;
        r.char_code = NEWLINE_CODE;
        repeat (len) issue(r);
        made += len;
      end else if (pick < 88) begin
        len = $urandom_range(1, 6);
        r.req_type = REQ_READ;
        repeat (len) begin
          sel = $urandom_range(0, 9);
          if (sel < 3)
            r.cell_index = INDEX_W'(mirror_row * SCREEN_WIDTH
                                    + $urandom_range(0, SCREEN_WIDTH - 1));
          else if (sel == 3) r.cell_index = INDEX_W'($urandom_range(CELL_COUNT, INDEX_MAX));
          else r.cell_index = INDEX_W'($urandom_range(0, CELL_COUNT - 1));
          r.char_code = CHAR_W'($urandom_range(0, 255));
          issue(r);
        end
        made += len;
      end else if (pick < 94) begin
        r.req_type = REQ_CLEAR;
        issue(r);
        made++;
      end else begin
        r.req_type = REQ_UNKNOWN;
        issue(r);
        made++;
      end
    end
  endtask

  task automatic note_field(string tag, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, tag, want_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst || calm) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      stall_left <= $urandom_range(0, 11);
      rsp_stall  <= ($urandom_range(0, 2) == 0);
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (replies_due.size() == 0) begin
        $display("%0t: response beat with nothing expected: expected none, actual 0x%0h",
                 $time, rsp);
        fails++;
      end else begin
        oldest_reply = replies_due.pop_front();
        note_field("cell_entry", oldest_reply.cell_entry, rsp.cell_entry);
        note_field("cursor_row", oldest_reply.cursor_row, rsp.cursor_row);
        note_field("cursor_col", oldest_reply.cursor_col, rsp.cursor_col);
        note_field("did_scroll", oldest_reply.did_scroll, rsp.did_scroll);
      end
    end
  end

  initial begin
    mirror_color = RESET_COLOR;
    mirror_fill(RESET_COLOR);

    add_step(REQ_READ, 8'h00, 11'd0, 1, 1'b1, status(INIT_CELL, 0, 0, 1'b0));
    add_step(REQ_READ, 8'hFF, INDEX_W'(CELL_COUNT - 1), 1, 1'b1,
             status(INIT_CELL, 0, 0, 1'b0));
    add_step(REQ_READ, 8'h00, INDEX_W'(CELL_COUNT), 1, 1'b1, status('0, 0, 0, 1'b0));
    add_step(REQ_READ, 8'h00, INDEX_W'(INDEX_MAX), 1, 1'b1, status('0, 0, 0, 1'b0));
    add_step(REQ_UNKNOWN, 8'hFF, INDEX_W'(INDEX_MAX), 1, 1'b1, status('0, 0, 0, 1'b0));
    add_step(REQ_PUT, 8'h41, 11'd0, 1);
    add_step(REQ_PUT, 8'h00, INDEX_W'(INDEX_MAX), 1);
    add_step(REQ_PUT, 8'hFF, 11'h555, 1);
    add_step(REQ_PUT, 8'h0D, 11'h2AA, 1);
    add_step(REQ_READ, 8'h00, 11'd2, 1);
    add_step(REQ_PUT, NEWLINE_CODE, 11'd0, 1, 1'b1, status('0, 1, 0, 1'b0));
    add_step(REQ_PUT, 8'h78, 11'd0, SCREEN_WIDTH);
    add_step(REQ_READ, 8'h00, INDEX_W'(SCREEN_WIDTH), 1);
    add_step(REQ_READ, 8'h00, INDEX_W'(2 * SCREEN_WIDTH - 1), 1);
    add_step(REQ_PUT, NEWLINE_CODE, 11'd0, SCREEN_HEIGHT - 3);
    add_step(REQ_PUT, 8'h7A, 11'd0, SCREEN_WIDTH - 1);
    add_step(REQ_PUT, 8'h21, 11'd0, 1);
    add_step(REQ_READ, 8'h00, 11'd0, 1);
    add_step(REQ_READ, 8'h00, INDEX_W'(CELL_COUNT - SCREEN_WIDTH), 1);
    add_step(REQ_PUT, NEWLINE_CODE, 11'd0, 1);
    add_step(REQ_PUT, 8'h55, 11'd0, 1);
    add_step(REQ_PUT, 8'hAA, 11'd0, 1);
    add_step(REQ_CLEAR, 8'h00, 11'd0, 1, 1'b1, status('0, 0, 0, 1'b0));
    add_step(REQ_READ, 8'h00, INDEX_W'(CELL_COUNT - 1), 1, 1'b1,
             status(INIT_CELL, 0, 0, 1'b0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_plan[s])
      repeat (opening_plan[s].reps) issue(opening_plan[s].beat, opening_plan[s].typed,
                                          opening_plan[s].want);

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) set_color(8'h00);
      else if (p == 1) set_color(8'hFF);
      else set_color(COLOR_W'($urandom_range(1, 254)));
      // drop all idling in the last phase
      calm = (p == PHASES - 1);
      run_phase(PHASE_ITEMS);
    end

    req_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d request beats: %0d puts, %0d reads, %0d clears, %0d scrolls.",
             beats_sent, puts_sent, reads_sent, clears_sent, scrolls_seen);
    $display("Text color written %0d times; random idling on both channels, none at the end.",
             color_writes);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_front.sv
rtl/tcw_back.sv
rtl/text_console_writer_top.sv
tb/tb.sv
